[rtl/tpr_pkg.sv]
// ----------------------------------------------------------------------------
// Trapezoid position ramp package
// Shared widths, register indexes, the configuration bundle and the
// controller/datapath command and status structs.
// ----------------------------------------------------------------------------
package tpr_pkg;

  localparam int POS_W   = 32;   // position fields
  localparam int SPD_W   = 24;   // measured speed and speed setpoint
  localparam int VMAX_W  = 23;   // speed clamp registers
  localparam int PAR_W   = 16;   // accel / decel / anticipation registers
  localparam int ADDR_W  = 5;    // eight 32-bit registers
  localparam int DATA_W  = 32;

  localparam int SQ_W    = 2 * SPD_W - 1;   // |speed|^2 fits in 47 bits
  localparam int ANT_W   = SPD_W + PAR_W;   // |speed| * gain
  localparam int DIST_W  = SQ_W;            // quotient + anticipation term
  localparam int PIV_W   = DIST_W + 1;      // signed pivot point
  localparam int DVS_W   = PAR_W + 1;       // 2 * deceleration
  localparam int DIV_STEPS = SQ_W;          // one quotient bit a cycle
  localparam int CNT_W   = $clog2(DIV_STEPS);

  // Register indexes (byte address = 4 * index)
  localparam logic [2:0] REG_MAX_SPEED_FWD    = 3'd0;
  localparam logic [2:0] REG_MAX_SPEED_REV    = 3'd1;
  localparam logic [2:0] REG_ACCEL_FWD        = 3'd2;
  localparam logic [2:0] REG_DECEL_FWD        = 3'd3;
  localparam logic [2:0] REG_ACCEL_REV        = 3'd4;
  localparam logic [2:0] REG_DECEL_REV        = 3'd5;
  localparam logic [2:0] REG_ANTICIPATION_FWD = 3'd6;
  localparam logic [2:0] REG_ANTICIPATION_REV = 3'd7;

  typedef struct packed {
    logic [VMAX_W-1:0] max_speed_fwd;
    logic [VMAX_W-1:0] max_speed_rev;
    logic [PAR_W-1:0]  accel_fwd;
    logic [PAR_W-1:0]  decel_fwd;
    logic [PAR_W-1:0]  accel_rev;
    logic [PAR_W-1:0]  decel_rev;
    logic [PAR_W-1:0]  anticipation_fwd;
    logic [PAR_W-1:0]  anticipation_rev;
  } cfg_t;

  typedef struct packed {
    logic load;       // capture input transfer
    logic mul;        // square and anticipation products
    logic div_step;   // one restoring division step
    logic sum;        // stopping distance
    logic pivot;      // pivot compare
    logic step;       // speed setpoint update
    logic commit;     // load result register
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;   // result register can take a new result
  } ctrl_sts_t;

endpackage

[rtl/tpr_regs.sv]
// ----------------------------------------------------------------------------
// Trapezoid position ramp configuration registers
// APB-style register file, eight registers at 4-byte spacing.
// ----------------------------------------------------------------------------
module tpr_regs (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tpr_pkg::ADDR_W-1:0] paddr,
  input  logic [tpr_pkg::DATA_W-1:0] pwdata,
  output logic [tpr_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  output tpr_pkg::cfg_t              cfg
);

  tpr_pkg::cfg_t cfg_r;
  logic [2:0]    idx;
  logic          wr_en;

  assign idx    = paddr[tpr_pkg::ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.max_speed_fwd    <= '0;
      cfg_r.max_speed_rev    <= '0;
      cfg_r.accel_fwd        <= '0;
      cfg_r.decel_fwd        <= tpr_pkg::PAR_W'(1);
      cfg_r.accel_rev        <= '0;
      cfg_r.decel_rev        <= tpr_pkg::PAR_W'(1);
      cfg_r.anticipation_fwd <= '0;
      cfg_r.anticipation_rev <= '0;
    end else if (wr_en) begin
      unique case (idx)
        tpr_pkg::REG_MAX_SPEED_FWD:    cfg_r.max_speed_fwd    <= pwdata[tpr_pkg::VMAX_W-1:0];
        tpr_pkg::REG_MAX_SPEED_REV:    cfg_r.max_speed_rev    <= pwdata[tpr_pkg::VMAX_W-1:0];
        tpr_pkg::REG_ACCEL_FWD:        cfg_r.accel_fwd        <= pwdata[tpr_pkg::PAR_W-1:0];
        tpr_pkg::REG_DECEL_FWD:        cfg_r.decel_fwd        <= pwdata[tpr_pkg::PAR_W-1:0];
        tpr_pkg::REG_ACCEL_REV:        cfg_r.accel_rev        <= pwdata[tpr_pkg::PAR_W-1:0];
        tpr_pkg::REG_DECEL_REV:        cfg_r.decel_rev        <= pwdata[tpr_pkg::PAR_W-1:0];
        tpr_pkg::REG_ANTICIPATION_FWD: cfg_r.anticipation_fwd <= pwdata[tpr_pkg::PAR_W-1:0];
        tpr_pkg::REG_ANTICIPATION_REV: cfg_r.anticipation_rev <= pwdata[tpr_pkg::PAR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      tpr_pkg::REG_MAX_SPEED_FWD:    prdata = tpr_pkg::DATA_W'(cfg_r.max_speed_fwd);
      tpr_pkg::REG_MAX_SPEED_REV:    prdata = tpr_pkg::DATA_W'(cfg_r.max_speed_rev);
      tpr_pkg::REG_ACCEL_FWD:        prdata = tpr_pkg::DATA_W'(cfg_r.accel_fwd);
      tpr_pkg::REG_DECEL_FWD:        prdata = tpr_pkg::DATA_W'(cfg_r.decel_fwd);
      tpr_pkg::REG_ACCEL_REV:        prdata = tpr_pkg::DATA_W'(cfg_r.accel_rev);
      tpr_pkg::REG_DECEL_REV:        prdata = tpr_pkg::DATA_W'(cfg_r.decel_rev);
      tpr_pkg::REG_ANTICIPATION_FWD: prdata = tpr_pkg::DATA_W'(cfg_r.anticipation_fwd);
      tpr_pkg::REG_ANTICIPATION_REV: prdata = tpr_pkg::DATA_W'(cfg_r.anticipation_rev);
      default:                       prdata = '0;
    endcase
  end

endmodule

[rtl/tpr_ctrl.sv]
// ----------------------------------------------------------------------------
// Trapezoid position ramp controller
// Sequences one item through multiply, divide, sum, pivot, update and commit steps.
// ----------------------------------------------------------------------------
module tpr_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  output tpr_pkg::ctrl_cmd_t    cmd,
  input  tpr_pkg::ctrl_sts_t    sts
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_DIV,
    S_SUM,
    S_PIVOT,
    S_STEP,
    S_COMMIT
  } state_t;

  localparam logic [tpr_pkg::CNT_W-1:0] CNT_LAST = tpr_pkg::CNT_W'(tpr_pkg::DIV_STEPS - 1);

  state_t                    state_r;
  logic [tpr_pkg::CNT_W-1:0] cnt_r;
  logic                      in_stall_r;

  assign in_stall = in_stall_r;

  always_comb begin
    cmd          = '0;
    cmd.load     = (state_r == S_IDLE) && in_valid;
    cmd.mul      = (state_r == S_MUL);
    cmd.div_step = (state_r == S_DIV);
    cmd.sum      = (state_r == S_SUM);
    cmd.pivot    = (state_r == S_PIVOT);
    cmd.step     = (state_r == S_STEP);
    cmd.commit   = (state_r == S_COMMIT) && sts.out_free;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      cnt_r      <= '0;
      in_stall_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            state_r    <= S_MUL;
            in_stall_r <= 1'b1;
          end
        end
        S_MUL: state_r <= S_DIV;
        S_DIV: begin
          if (cnt_r == CNT_LAST) begin
            cnt_r   <= '0;
            state_r <= S_SUM;
          end else begin
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SUM:   state_r <= S_PIVOT;
        S_PIVOT: state_r <= S_STEP;
        S_STEP:  state_r <= S_COMMIT;
        S_COMMIT: begin
          if (sts.out_free) begin
            state_r    <= S_IDLE;
            in_stall_r <= 1'b0;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_load_starts: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_MUL) && in_stall)
    else $error("load did not start the sequence");

  a_div_len: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV) && (cnt_r == CNT_LAST) |=> (state_r == S_SUM))
    else $error("divide did not end after its last step");

  a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_DIV) |-> (cnt_r == '0))
    else $error("step counter not clear outside divide");

  a_commit_frees: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> !in_stall && (state_r == S_IDLE))
    else $error("input still stalled after commit");

endmodule

[rtl/tpr_dpath.sv]
// ----------------------------------------------------------------------------
// Trapezoid position ramp datapath
// Products, restoring divider, pivot compare, setpoint update, result register.
// ----------------------------------------------------------------------------
module tpr_dpath #(
  parameter int unsigned ARRIVAL_WINDOW = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  tpr_pkg::ctrl_cmd_t                cmd,
  output tpr_pkg::ctrl_sts_t                sts,
  input  tpr_pkg::cfg_t                     cfg,
  input  logic signed [tpr_pkg::POS_W-1:0]  in_target_position,
  input  logic signed [tpr_pkg::POS_W-1:0]  in_current_position,
  input  logic signed [tpr_pkg::SPD_W-1:0]  in_current_speed,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tpr_pkg::POS_W-1:0]  out_position_setpoint,
  output logic                              out_arrived
);

  localparam int POS_W  = tpr_pkg::POS_W;
  localparam int SPD_W  = tpr_pkg::SPD_W;
  localparam int ERR_W  = POS_W + 1;
  localparam int SUM_W  = SPD_W + 1;
  localparam int PIV_W  = tpr_pkg::PIV_W;
  localparam int DVS_W  = tpr_pkg::DVS_W;
  localparam int SQ_W   = tpr_pkg::SQ_W;

  localparam logic signed [ERR_W-1:0] WIN     = ERR_W'(ARRIVAL_WINDOW);
  localparam logic signed [ERR_W-1:0] WIN_NEG = -WIN;

  // captured item
  logic signed [POS_W-1:0]      tgt_r, pos_r;
  logic signed [ERR_W-1:0]      err_r;
  logic                         fwd_r, neg_r, arrive_r;
  logic [SPD_W-1:0]             mag_r;
  logic [tpr_pkg::PAR_W-1:0]    gain_r;
  logic [DVS_W-1:0]             dvs_r;

  // products and divider
  logic [SQ_W-1:0]              quo_r;
  logic [DVS_W-1:0]             rem_r;
  logic [tpr_pkg::ANT_W-1:0]    ant_r;
  logic [tpr_pkg::DIST_W-1:0]   dist_r;
  logic                         ge_r;

  // speed state and result
  logic signed [SPD_W-1:0]      spd_set_r, sp_r;
  logic signed [POS_W-1:0]      out_pos_r;
  logic                         out_arr_r, out_valid_r;

  logic signed [ERR_W-1:0]      err;
  logic [tpr_pkg::PAR_W-1:0]    dsel;
  logic [2*SPD_W-1:0]           sq;
  logic [DVS_W:0]               rem_sh;
  logic                         q_bit;
  logic signed [PIV_W-1:0]      tgt_w, pos_w, dist_w, piv;
  logic [tpr_pkg::PAR_W-1:0]    acc_mag;
  logic signed [SUM_W-1:0]      sp_sum, lo, hi, sp_cl;
  logic signed [ERR_W-1:0]      res;
  logic signed [POS_W-1:0]      res_sat;

  assign sts.out_free = !out_valid_r || !out_stall;

  // load stage
  assign err  = ERR_W'(in_target_position) - ERR_W'(in_current_position);
  assign dsel = err[ERR_W-1] ? cfg.decel_rev : cfg.decel_fwd;

  // divider step
  assign sq     = mag_r * mag_r;
  assign rem_sh = {rem_r, quo_r[SQ_W-1]};
  assign q_bit  = rem_sh >= {1'b0, dvs_r};

  // pivot
  assign tgt_w  = PIV_W'(tgt_r);
  assign pos_w  = PIV_W'(pos_r);
  assign dist_w = $signed({1'b0, dist_r});
  assign piv    = neg_r ? tgt_w + dist_w : tgt_w - dist_w;

  // setpoint update
  always_comb begin
    if (ge_r) acc_mag = fwd_r ? cfg.accel_fwd : cfg.decel_rev;
    else      acc_mag = fwd_r ? cfg.decel_fwd : cfg.accel_rev;
  end

  assign sp_sum = ge_r ? SUM_W'(spd_set_r) + $signed({1'b0, acc_mag})
                       : SUM_W'(spd_set_r) - $signed({1'b0, acc_mag});
  assign hi     = $signed({2'b00, cfg.max_speed_fwd});
  assign lo     = -$signed({2'b00, cfg.max_speed_rev});
  assign sp_cl  = (sp_sum < lo) ? lo : ((sp_sum > hi) ? hi : sp_sum);

  // result
  assign res = ERR_W'(pos_r) + ERR_W'(sp_r);
  always_comb begin
    if (res[ERR_W-1] != res[ERR_W-2])
      res_sat = res[ERR_W-1] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
    else
      res_sat = res[POS_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      tgt_r  <= in_target_position;
      pos_r  <= in_current_position;
      err_r  <= err;
      fwd_r  <= !err[ERR_W-1];
      neg_r  <= in_current_speed[SPD_W-1];
      mag_r  <= in_current_speed[SPD_W-1] ? SPD_W'(-in_current_speed) : in_current_speed;
      gain_r <= err[ERR_W-1] ? cfg.anticipation_rev : cfg.anticipation_fwd;
      dvs_r  <= {((dsel == '0) ? tpr_pkg::PAR_W'(1) : dsel), 1'b0};
    end
    if (cmd.mul) begin
      quo_r    <= sq[SQ_W-1:0];
      ant_r    <= mag_r * gain_r;
      rem_r    <= '0;
      arrive_r <= (err_r < WIN) && (err_r > WIN_NEG);
    end
    if (cmd.div_step) begin
      rem_r <= q_bit ? DVS_W'(rem_sh - {1'b0, dvs_r}) : rem_sh[DVS_W-1:0];
      quo_r <= {quo_r[SQ_W-2:0], q_bit};
    end
    if (cmd.sum)   dist_r <= quo_r + tpr_pkg::DIST_W'(ant_r);
    if (cmd.pivot) ge_r   <= piv >= pos_w;
    if (cmd.step)  sp_r   <= sp_cl[SPD_W-1:0];
    if (cmd.commit) begin
      out_pos_r <= arrive_r ? tgt_r : res_sat;
      out_arr_r <= arrive_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spd_set_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.step)
        spd_set_r <= arrive_r ? '0 : sp_cl[SPD_W-1:0];
      if (cmd.commit)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_position_setpoint = out_pos_r;
  assign out_arrived           = out_arr_r;

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_step |=> (rem_r < dvs_r))
    else $error("divider remainder not below divisor");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_valid_r || !out_stall))
    else $error("result overwritten before transfer");

  a_arrive_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && arrive_r |=> (spd_set_r == '0))
    else $error("speed setpoint not cleared on arrival");

  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_valid && (out_arrived == $past(arrive_r)))
    else $error("result register not loaded on commit");

endmodule

[rtl/trapezoid_position_ramp_unit.sv]
// ----------------------------------------------------------------------------
// Trapezoid position ramp unit
// Trapezoidal speed-profile generator producing one position command a tick.
// ----------------------------------------------------------------------------
// Each transfer on the in_ channel carries one control tick: target position,
// measured position and measured speed. The unit brakes at a pivot lying
// speed^2/(2*decel) + |speed|*anticipation before the target, accelerates
// before it and decelerates past it, clamps and keeps the speed setpoint,
// and returns position + setpoint (saturated) or the target itself with
// arrived set once |target - position| < ARRIVAL_WINDOW. The restoring
// divider yields one of the 47 quotient bits a cycle; it runs after the
// multiply step and before the sum, pivot, setpoint update and commit
// steps, and no new input is taken until the commit step. The input is
// taken while a finished result still waits in the output register; only
// the final update waits for that register to drain. Registers sit on an
// APB-style port at byte addresses 0x00..0x1C; the user must write them
// only while the unit is idle, as the unit itself does not enforce this.
// ----------------------------------------------------------------------------
module trapezoid_position_ramp_unit #(
  parameter int unsigned ARRIVAL_WINDOW = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // input channel
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [tpr_pkg::POS_W-1:0]  in_target_position,
  input  logic signed [tpr_pkg::POS_W-1:0]  in_current_position,
  input  logic signed [tpr_pkg::SPD_W-1:0]  in_current_speed,
  // result channel
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [tpr_pkg::POS_W-1:0]  out_position_setpoint,
  output logic                              out_arrived,
  // configuration port
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [tpr_pkg::ADDR_W-1:0]        paddr,
  input  logic [tpr_pkg::DATA_W-1:0]        pwdata,
  output logic [tpr_pkg::DATA_W-1:0]        prdata,
  output logic                              pready
);

  tpr_pkg::cfg_t      cfg;
  tpr_pkg::ctrl_cmd_t cmd;
  tpr_pkg::ctrl_sts_t sts;

  // register file
  tpr_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // sequencer: idle -> multiply -> 47 divide steps -> sum -> pivot ->
  // setpoint update -> commit
  tpr_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .sts      (sts)
  );

  // arithmetic, speed setpoint state and output register
  tpr_dpath #(
    .ARRIVAL_WINDOW (ARRIVAL_WINDOW)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .cfg                   (cfg),
    .in_target_position    (in_target_position),
    .in_current_position   (in_current_position),
    .in_current_speed      (in_current_speed),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_position_setpoint (out_position_setpoint),
    .out_arrived           (out_arrived)
  );

endmodule

[tb/tb_trapezoid_position_ramp_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoid position ramp unit testbench
// Drives control ticks into the unit, predicts each position command with a
// local copy of the speed-profile arithmetic and compares every result
// transfer field by field. Covers register access and masking, field
// extremes, arrival, clamping, saturation and zero deceleration, then
// closed-loop moves under a series of register settings with random idling
// on both channels and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_trapezoid_position_ramp_unit;
  import tpr_pkg::*;

  // --------------------------------------------------------------------------
  // Run parameters
  // --------------------------------------------------------------------------
  localparam int     CLK_HALF       = 2;          // 4 ns period
  localparam int     RESET_CYCLES   = 5;
  localparam int     ARRIVAL_WINDOW = 16;
  localparam int     ITEMS          = 1450;       // ticks over the whole run
  localparam int     NUM_REGS       = 8;
  localparam int     NUM_KINDS      = 8;          // register settings in the random part
  localparam int     RX_HOLD_CYCLES = 400;        // long output hold-off
  localparam int     END_WAIT       = 120;        // > one tick of latency
  localparam longint TIMEOUT_NS     = 4_000_000;  // several times the need
  localparam int     MAX_PRINTS     = 50;

  localparam longint POS_MAX = 64'sd2147483647;
  localparam longint POS_MIN = -64'sd2147483648;
  localparam longint SPD_MAX = 64'sd8388607;
  localparam longint SPD_MIN = -64'sd8388608;
  localparam logic [DATA_W-1:0] VMAX_ALL = (32'd1 << VMAX_W) - 1;
  localparam logic [DATA_W-1:0] PAR_ALL  = (32'd1 << PAR_W) - 1;

  // One predicted position command
  typedef struct {
    logic signed [POS_W-1:0] position;
    logic                    arrived;
  } setpoint_t;

  // --------------------------------------------------------------------------
  // DUT connections; every input known from time zero
  // --------------------------------------------------------------------------
  logic                     clk   = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [POS_W-1:0]  in_target_position  = '0;
  logic signed [POS_W-1:0]  in_current_position = '0;
  logic signed [SPD_W-1:0]  in_current_speed    = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [POS_W-1:0]  out_position_setpoint;
  logic                     out_arrived;
  logic                     psel    = 1'b0;
  logic                     penable = 1'b0;
  logic                     pwrite  = 1'b0;
  logic [ADDR_W-1:0]        paddr   = '0;
  logic [DATA_W-1:0]        pwdata  = '0;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  trapezoid_position_ramp_unit #(
    .ARRIVAL_WINDOW(ARRIVAL_WINDOW)
  ) u_dut (
    .clk                  (clk),
    .rst_n                (rst_n),
    .in_valid             (in_valid),
    .in_stall             (in_stall),
    .in_target_position   (in_target_position),
    .in_current_position  (in_current_position),
    .in_current_speed     (in_current_speed),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_position_setpoint(out_position_setpoint),
    .out_arrived          (out_arrived),
    .psel                 (psel),
    .penable              (penable),
    .pwrite               (pwrite),
    .paddr                (paddr),
    .pwdata               (pwdata),
    .prdata               (prdata),
    .pready               (pready)
  );

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Predictor state: register copy and the stored speed setpoint
  // --------------------------------------------------------------------------
  cfg_t                    ramp_cfg;
  logic signed [SPD_W-1:0] speed_sp;
  setpoint_t               setpoint_q[$];   // predicted commands, oldest first
  int                      ticks_sent = 0;
  int                      n_mismatch = 0;

  // Idling controls. The sink flags are read by the sink process, so they are
  // written with nonblocking assignments.
  bit   tx_gaps_on    = 1'b1;
  logic rx_stalls_on  = 1'b1;
  logic rx_hold_start = 1'b0;

  // Sink bookkeeping
  int rx_since     = 0;
  int rx_lead      = 0;
  int rx_len       = 0;
  int rx_hold_left = 0;

  task automatic report_mismatch(input string what);
    if (n_mismatch < MAX_PRINTS) $display("%0t ns  mismatch: %s", $time, what);
    n_mismatch++;
  endtask

  function automatic longint clip(input longint v, input longint lo, input longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Random value whose magnitude spans from tiny to the full width
  function automatic logic [DATA_W-1:0] rand_width(input int w);
    return $urandom & ((32'd1 << $urandom_range(0, w)) - 1);
  endfunction

  // --------------------------------------------------------------------------
  // Position command predictor. Works in 64-bit signed arithmetic so nothing
  // overflows; division of non-negative values, so truncation is exact.
  // Updates the stored speed setpoint as a side effect.
  // --------------------------------------------------------------------------
  function automatic setpoint_t predict_setpoint(input logic signed [POS_W-1:0] tgt,
                                                 input logic signed [POS_W-1:0] pos,
                                                 input logic signed [SPD_W-1:0] spd);
    longint    t, p, s, err, mag, dvs, gain, brake_len, pivot, acc, sp, lo, hi, sum;
    logic      fwd;
    setpoint_t r;
    t    = tgt;
    p    = pos;
    s    = spd;
    err  = t - p;
    fwd  = (err >= 0);                 // zero error counts as forward
    mag  = (s < 0) ? -s : s;
    if (fwd) begin
      dvs  = ramp_cfg.decel_fwd;
      gain = ramp_cfg.anticipation_fwd;
    end else begin
      dvs  = ramp_cfg.decel_rev;
      gain = ramp_cfg.anticipation_rev;
    end
    if (dvs == 0) dvs = 1;             // zero deceleration counts as one
    brake_len = (mag * mag) / (2 * dvs) + mag * gain;
    pivot     = (s >= 0) ? t - brake_len : t + brake_len;
    // reaching the pivot still accelerates; a zero register is a zero step
    if (pivot >= p) begin
      acc = fwd ? longint'(ramp_cfg.accel_fwd) : longint'(ramp_cfg.decel_rev);
    end else begin
      acc = fwd ? longint'(ramp_cfg.decel_fwd) : longint'(ramp_cfg.accel_rev);
      acc = -acc;
    end
    lo = ramp_cfg.max_speed_rev;
    lo = -lo;
    hi = ramp_cfg.max_speed_fwd;
    sp = clip(speed_sp + acc, lo, hi);
    speed_sp = SPD_W'(sp);
    if (((err < 0) ? -err : err) < ARRIVAL_WINDOW) begin
      speed_sp   = '0;
      r.position = tgt;
      r.arrived  = 1'b1;
    end else begin
      sum        = clip(p + sp, POS_MIN, POS_MAX);
      r.position = POS_W'(sum);
      r.arrived  = 1'b0;
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Tick sender: random gap, then hold the tick until its transfer. The
  // prediction is made at the transfer so it follows acceptance order.
  // Leaves in_valid high; the next send or drain decides what follows.
  // --------------------------------------------------------------------------
  task automatic send_tick(input longint tgt, input longint pos, input longint spd,
                           output setpoint_t want);
    logic signed [POS_W-1:0] t_v, p_v;
    logic signed [SPD_W-1:0] s_v;
    int                      gap;
    t_v = POS_W'(tgt);
    p_v = POS_W'(pos);
    s_v = SPD_W'(spd);
    gap = tx_gaps_on ? $urandom_range(0, 4) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid            <= 1'b1;
    in_target_position  <= t_v;
    in_current_position <= p_v;
    in_current_speed    <= s_v;
    do @(posedge clk); while (in_stall);
    want = predict_setpoint(t_v, p_v, s_v);
    setpoint_q.push_back(want);
    ticks_sent++;
  endtask

  // Sender pause: offer nothing until every predicted command has come back.
  // Every tick yields a result, so an empty queue means the unit is idle.
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (setpoint_q.size() != 0);
  endtask

  // --------------------------------------------------------------------------
  // Register port: setup cycle, access cycle, then an idle cycle after
  // --------------------------------------------------------------------------
  task automatic reg_write(input logic [2:0] idx, input logic [DATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAX_SPEED_FWD:    ramp_cfg.max_speed_fwd    = data[VMAX_W-1:0];
      REG_MAX_SPEED_REV:    ramp_cfg.max_speed_rev    = data[VMAX_W-1:0];
      REG_ACCEL_FWD:        ramp_cfg.accel_fwd        = data[PAR_W-1:0];
      REG_DECEL_FWD:        ramp_cfg.decel_fwd        = data[PAR_W-1:0];
      REG_ACCEL_REV:        ramp_cfg.accel_rev        = data[PAR_W-1:0];
      REG_DECEL_REV:        ramp_cfg.decel_rev        = data[PAR_W-1:0];
      REG_ANTICIPATION_FWD: ramp_cfg.anticipation_fwd = data[PAR_W-1:0];
      REG_ANTICIPATION_REV: ramp_cfg.anticipation_rev = data[PAR_W-1:0];
      default: ;
    endcase
  endtask

  // Read a register back and compare with the masked value held locally
  task automatic check_register(input logic [2:0] idx);
    logic [DATA_W-1:0] got, want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    got = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_MAX_SPEED_FWD:    want = DATA_W'(ramp_cfg.max_speed_fwd);
      REG_MAX_SPEED_REV:    want = DATA_W'(ramp_cfg.max_speed_rev);
      REG_ACCEL_FWD:        want = DATA_W'(ramp_cfg.accel_fwd);
      REG_DECEL_FWD:        want = DATA_W'(ramp_cfg.decel_fwd);
      REG_ACCEL_REV:        want = DATA_W'(ramp_cfg.accel_rev);
      REG_DECEL_REV:        want = DATA_W'(ramp_cfg.decel_rev);
      REG_ANTICIPATION_FWD: want = DATA_W'(ramp_cfg.anticipation_fwd);
      default:              want = DATA_W'(ramp_cfg.anticipation_rev);
    endcase
    if (got !== want)
      report_mismatch($sformatf("register %0d reads 0x%08h, held 0x%08h", idx, got, want));
  endtask

  task automatic program_ramp(input logic [DATA_W-1:0] vmax_f, input logic [DATA_W-1:0] vmax_r,
                              input logic [DATA_W-1:0] acc_f, input logic [DATA_W-1:0] dec_f,
                              input logic [DATA_W-1:0] acc_r, input logic [DATA_W-1:0] dec_r,
                              input logic [DATA_W-1:0] ant_f, input logic [DATA_W-1:0] ant_r);
    reg_write(REG_MAX_SPEED_FWD, vmax_f);
    reg_write(REG_MAX_SPEED_REV, vmax_r);
    reg_write(REG_ACCEL_FWD, acc_f);
    reg_write(REG_DECEL_FWD, dec_f);
    reg_write(REG_ACCEL_REV, acc_r);
    reg_write(REG_DECEL_REV, dec_r);
    reg_write(REG_ANTICIPATION_FWD, ant_f);
    reg_write(REG_ANTICIPATION_REV, ant_r);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus building blocks
  // --------------------------------------------------------------------------
  // Unstructured ticks: every bit of every field random
  task automatic noise_burst(input int n);
    setpoint_t got;
    for (int k = 0; k < n; k++)
      send_tick($signed($urandom), $signed($urandom), $signed($urandom), got);
  endtask

  // Closed-loop move: the next measured position follows the last command,
  // speed is the position step. Occasional jumps break the sequence.
  task automatic run_move();
    longint    base, span, tgt, pos, nxt, spd;
    int        cap;
    setpoint_t got;
    base = (ramp_cfg.max_speed_fwd > ramp_cfg.max_speed_rev) ?
           longint'(ramp_cfg.max_speed_fwd) : longint'(ramp_cfg.max_speed_rev);
    base = base + 1;
    span = base * $urandom_range(2, 40) + $urandom_range(0, 32'(base));
    case ($urandom_range(0, 9))
      0:       tgt = POS_MAX - $urandom_range(0, 200);
      1:       tgt = POS_MIN + $urandom_range(0, 200);
      default: tgt = $signed($urandom) >>> $urandom_range(0, 24);
    endcase
    pos = clip($urandom_range(0, 1) ? tgt + span : tgt - span, POS_MIN, POS_MAX);
    spd = 0;
    cap = $urandom_range(20, 80);
    for (int k = 0; k < cap; k++) begin
      send_tick(tgt, pos, spd, got);
      if (got.arrived) break;
      nxt = got.position;
      if ($urandom_range(0, 19) == 0) nxt = clip(nxt + $signed(8'($urandom)), POS_MIN, POS_MAX);
      spd = clip(nxt - pos, SPD_MIN, SPD_MAX);
      pos = nxt;
      if ($urandom_range(0, 39) == 0) spd = $signed(24'($urandom));
      if ($urandom_range(0, 59) == 0) pos = $signed($urandom);
    end
  endtask

  task automatic apply_setting(input int kind);
    case (kind)
      0: program_ramp($urandom_range(200, 3000), $urandom_range(200, 3000),
                      $urandom_range(5, 200), $urandom_range(5, 200),
                      $urandom_range(5, 200), $urandom_range(5, 200),
                      $urandom_range(0, 2), $urandom_range(0, 2));
      // every register at its top value
      1: program_ramp(VMAX_ALL, VMAX_ALL, PAR_ALL, PAR_ALL, PAR_ALL, PAR_ALL,
                      PAR_ALL, PAR_ALL);
      // zero deceleration in both directions
      2: program_ramp($urandom_range(100, 800), $urandom_range(100, 800),
                      $urandom_range(30, 90), 0, $urandom_range(30, 90), 0, 0, 0);
      3: program_ramp($urandom_range(4000, 60000), $urandom_range(50, 500),
                      $urandom_range(100, 4000), $urandom_range(1, 30),
                      $urandom_range(5, 40), $urandom_range(100, 3000),
                      $urandom_range(0, 20), $urandom_range(0, 20));
      // no forward motion allowed
      4: program_ramp(0, $urandom_range(500, 5000), 0, $urandom_range(10, 100),
                      $urandom_range(10, 100), $urandom_range(10, 100),
                      $urandom_range(0, 5), $urandom_range(0, 5));
      default: program_ramp(rand_width(VMAX_W), rand_width(VMAX_W),
                            rand_width(PAR_W), rand_width(PAR_W),
                            rand_width(PAR_W), rand_width(PAR_W),
                            rand_width(PAR_W), rand_width(PAR_W));
    endcase
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------
  // Reset register values, then a few ticks with both clamps at zero
  task automatic test_reset_state();
    setpoint_t got;
    for (int i = 0; i < NUM_REGS; i++) check_register(3'(i));
    send_tick(100, 0, 5, got);
    send_tick(-100, 0, -5, got);
    send_tick(3, 0, 0, got);
    drain_results();
  endtask

  // Writes mask to each register's width and read back as held
  task automatic test_register_masking();
    program_ramp('1, '1, '1, '1, '1, '1, '1, '1);
    for (int i = 0; i < NUM_REGS; i++) check_register(3'(i));
    program_ramp($urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
                 $urandom, $urandom);
    for (int i = 0; i < NUM_REGS; i++) check_register(3'(i));
  endtask

  // Field extremes, arrival edges, clamps, saturation and pivot branches
  task automatic test_directed_ticks();
    setpoint_t got;
    program_ramp(150, 100, 100, 40, 60, 70, 2, 3);
    send_tick(0, 0, 0, got);                       // zero error, forward
    send_tick(15, 0, 0, got);                      // just inside the window
    send_tick(-15, 0, 0, got);
    send_tick(16, 0, 0, got);                      // just outside
    send_tick(-16, 0, 0, got);
    send_tick(POS_MAX, POS_MIN, SPD_MAX, got);     // largest error, both speeds
    send_tick(POS_MIN, POS_MAX, SPD_MIN, got);
    send_tick(POS_MAX, POS_MIN, SPD_MIN, got);
    send_tick(POS_MIN, POS_MAX, SPD_MAX, got);
    // upward saturation after clearing the setpoint; third tick hits the clamp
    send_tick(POS_MAX, POS_MAX, 0, got);
    send_tick(POS_MAX, POS_MAX - 50, 0, got);
    send_tick(POS_MAX, POS_MAX - 50, 0, got);
    // downward saturation and the reverse clamp
    send_tick(POS_MIN, POS_MIN, 0, got);
    send_tick(POS_MIN, POS_MIN + 50, 0, got);
    send_tick(POS_MIN, POS_MIN + 50, 0, got);
    // before and past the pivot in both directions
    send_tick(1000, 0, 500, got);
    send_tick(1000, 0, -500, got);
    send_tick(-1000, 0, -500, got);
    send_tick(-1000, 0, 500, got);
    drain_results();
    // zero deceleration: treated as one in the divisor, zero-sized steps
    reg_write(REG_DECEL_FWD, 0);
    reg_write(REG_DECEL_REV, 0);
    send_tick(1000, 0, 40, got);
    send_tick(-1000, 0, -40, got);
    send_tick(1000, 0, -40, got);
    send_tick(-1000, 0, 40, got);
    drain_results();
  endtask

  // The sink holds off long enough for the unit to fill and stall its input;
  // then the sender pauses until everything has come back.
  task automatic test_output_backpressure();
    apply_setting(0);
    tx_gaps_on    = 1'b0;
    rx_hold_start <= 1'b1;
    @(posedge clk);
    rx_hold_start <= 1'b0;
    noise_burst(8);
    drain_results();
    noise_burst(4);
    drain_results();
    tx_gaps_on = 1'b1;
  endtask

  // Closed-loop moves under a series of settings, with noise mixed in.
  // Every third setting runs with no idling on either side.
  task automatic test_move_profiles();
    int quota;
    for (int kind = 0; kind < NUM_KINDS; kind++) begin
      drain_results();
      apply_setting(kind);
      tx_gaps_on   = (kind % 3 != 0);
      rx_stalls_on <= (kind % 3 != 0);
      quota = ticks_sent + (ITEMS - ticks_sent) / (NUM_KINDS - kind);
      while (ticks_sent < quota) begin
        if ($urandom_range(0, 4) == 0) noise_burst($urandom_range(1, 6));
        else run_move();
      end
    end
    drain_results();
  endtask

  // --------------------------------------------------------------------------
  // Result sink: after each transfer draws a stall of random length placed at
  // a random distance, mostly around where the next result lands, so stalls
  // hit every phase. A hold request overrides it for RX_HOLD_CYCLES.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : result_sink
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (rx_hold_start) rx_hold_left = RX_HOLD_CYCLES;
      if (out_valid && !out_stall) begin
        rx_since = 0;
        rx_lead  = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 56) :
                                                 $urandom_range(46, 54);
        rx_len   = rx_stalls_on ? $urandom_range(0, 4) : 0;
      end else begin
        rx_since++;
      end
      if (rx_hold_left > 0) begin
        rx_hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= (rx_since + 1 >= rx_lead) && (rx_since + 1 < rx_lead + rx_len);
      end
    end
  end

  // Result check against the oldest prediction
  always @(posedge clk) begin : result_check
    setpoint_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (setpoint_q.size() == 0) begin
        report_mismatch("result transfer with no tick outstanding");
      end else begin
        want = setpoint_q.pop_front();
        if (out_position_setpoint !== want.position)
          report_mismatch($sformatf("position_setpoint %0d, predicted %0d",
                                    out_position_setpoint, want.position));
        if (out_arrived !== want.arrived)
          report_mismatch($sformatf("arrived %0b, predicted %0b", out_arrived,
                                    want.arrived));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    ramp_cfg          = '0;
    ramp_cfg.decel_fwd = 1;
    ramp_cfg.decel_rev = 1;
    speed_sp          = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_state();
    test_register_masking();
    test_directed_ticks();
    test_output_backpressure();
    test_move_profiles();

    // let any stray result show up before the verdict
    drain_results();
    repeat (END_WAIT) @(posedge clk);
    if (n_mismatch == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d commands outstanding", setpoint_q.size());
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/tpr_pkg.sv
rtl/tpr_regs.sv
rtl/tpr_ctrl.sv
rtl/tpr_dpath.sv
rtl/trapezoid_position_ramp_unit.sv
tb/tb_trapezoid_position_ramp_unit.sv
